### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the frame encoder
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every clock edge out of reset
`define ASSERT_HOLDS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");

// condition that implies another in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition that implies another in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/ecfe_pkg.sv
// ---------------------------------------------------------------------------
// ecfe_pkg
// types, constants and crc function of the escaped crc16 frame encoder
// ---------------------------------------------------------------------------
`default_nettype none

package ecfe_pkg;

    // framing
    localparam int PREAMBLE_COUNT = 8;
    localparam int HDR_BYTES      = 14;
    localparam int HDR_IDX_W      = $clog2(HDR_BYTES);
    localparam int CNT_W          = $clog2((PREAMBLE_COUNT > HDR_BYTES) ?
                                           PREAMBLE_COUNT : HDR_BYTES);

    // line byte codes
    localparam logic [7:0] BYTE_PREAMBLE = 8'hA5;
    localparam logic [7:0] BYTE_ESC_A    = 8'hA6;
    localparam logic [7:0] BYTE_TAIL     = 8'h5A;
    localparam logic [7:0] BYTE_ESC_B    = 8'h5B;
    localparam logic [7:0] BYTE_SUB_2    = 8'h02;
    localparam logic [7:0] BYTE_SUB_1    = 8'h01;
    localparam logic [7:0] BYTE_ZERO     = 8'h00;

    // crc-16/arc, reflected
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // register map
    localparam int          ADDR_W       = 4;
    localparam logic [1:0]  REG_DEST     = 2'd0;
    localparam logic [1:0]  REG_SOURCE   = 2'd1;
    localparam logic [1:0]  REG_PROTOCOL = 2'd2;
    localparam logic [15:0] DEST_RESET     = 16'h0001;
    localparam logic [15:0] SOURCE_RESET   = 16'h8000;
    localparam logic [15:0] PROTOCOL_RESET = 16'h02FE;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified input word
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] field_length;
        logic        last_byte;
        logic        first_byte;
    } ecfe_entry_t;

    // header words from the register file
    typedef struct packed {
        logic [15:0] dest_address;
        logic [15:0] source_address;
        logic [15:0] protocol_word;
    } ecfe_hdr_t;

    // one byte through the reflected crc
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                                input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/ecfe_front.sv
// ---------------------------------------------------------------------------
// ecfe_front
// accepts input words, tracks frame state and marks a frame's first byte
// ---------------------------------------------------------------------------
`default_nettype none

module ecfe_front (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire  [23:0]           s_tdata,   // data_byte[7:0], field_length[23:8]
    input  wire                   s_tlast,   // last_byte
    output logic                  push_valid,
    input  wire                   push_ready,
    output ecfe_pkg::ecfe_entry_t push_entry
);
    import ecfe_pkg::*;

    logic in_frame_reg;
    logic in_frame_next;
    logic accept;

    // handshake follows queue space
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign accept     = s_tvalid && push_ready;

    // classify the word
    always_comb
    begin
        push_entry.data_byte    = s_tdata[7:0];
        push_entry.field_length = s_tdata[23:8];
        push_entry.last_byte    = s_tlast;
        push_entry.first_byte   = !in_frame_reg;
    end

    // frame open after a non-last word
    always_comb
    begin
        in_frame_next = in_frame_reg;
        if (accept)
            in_frame_next = !s_tlast;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_frame_reg <= 1'b0;
        else
            in_frame_reg <= in_frame_next;
    end

endmodule

`default_nettype wire

### sv/ecfe_queue.sv
// ---------------------------------------------------------------------------
// ecfe_queue
// short fifo of classified words between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module ecfe_queue (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push_valid,
    output logic                  push_ready,
    input  ecfe_pkg::ecfe_entry_t push_entry,
    output logic                  pop_valid,
    input  wire                   pop_ready,
    output ecfe_pkg::ecfe_entry_t pop_entry,
    output logic [ecfe_pkg::QCNT_W-1:0] count
);
    import ecfe_pkg::*;

    ecfe_entry_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg;
    logic [QCNT_W-1:0]  cnt_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign count      = cnt_reg;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

### sv/ecfe_back.sv
// ---------------------------------------------------------------------------
// ecfe_back
// byte sequencer: preamble, header, data, crc and tail with byte stuffing
// ---------------------------------------------------------------------------
`default_nettype none

module ecfe_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  ecfe_pkg::ecfe_hdr_t   hdr,
    input  wire                   pop_valid,
    output logic                  pop_ready,
    input  ecfe_pkg::ecfe_entry_t pop_entry,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [7:0]            m_tdata,   // line_byte
    output logic                  m_tlast,   // run_last
    output logic                  m_tuser    // frame_end
);
    import ecfe_pkg::*;

    localparam logic [2:0] PH_PRE  = 3'd0;
    localparam logic [2:0] PH_HDR  = 3'd1;
    localparam logic [2:0] PH_DATA = 3'd2;
    localparam logic [2:0] PH_CLO  = 3'd3;
    localparam logic [2:0] PH_CHI  = 3'd4;
    localparam logic [2:0] PH_TAIL = 3'd5;

    logic              active_reg,  active_next;
    logic [2:0]        phase_reg,   phase_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;
    logic              esc_reg,     esc_next;
    logic [15:0]       crc_reg,     crc_next;
    ecfe_entry_t       ent_reg,     ent_next;
    logic              ovalid_reg,  ovalid_next;
    logic [7:0]        obyte_reg,   obyte_next;
    logic              olast_reg,   olast_next;
    logic              oend_reg,    oend_next;

    logic [7:0]        hdr_bytes [HDR_BYTES];
    logic [7:0]        raw;
    logic              stuffed;
    logic              crc_phase;
    logic              special;
    logic [7:0]        emit;
    logic              byte_done;
    logic              entry_done;
    logic              step;
    logic              load;

    // header bytes, little-endian words
    always_comb
    begin
        for (int i = 0; i < HDR_BYTES; i++)
            hdr_bytes[i] = BYTE_ZERO;
        hdr_bytes[0]  = hdr.dest_address[7:0];
        hdr_bytes[1]  = hdr.dest_address[15:8];
        hdr_bytes[2]  = hdr.source_address[7:0];
        hdr_bytes[3]  = hdr.source_address[15:8];
        hdr_bytes[10] = hdr.protocol_word[7:0];
        hdr_bytes[11] = hdr.protocol_word[15:8];
        hdr_bytes[12] = ent_reg.field_length[7:0];
        hdr_bytes[13] = ent_reg.field_length[15:8];
    end

    // raw byte of the current phase
    always_comb
    begin
        raw       = BYTE_PREAMBLE;
        stuffed   = 1'b0;
        crc_phase = 1'b0;
        case (phase_reg)
            PH_PRE:
            begin
                raw = BYTE_PREAMBLE;
            end
            PH_HDR:
            begin
                raw       = hdr_bytes[cnt_reg[HDR_IDX_W-1:0]];
                stuffed   = 1'b1;
                crc_phase = 1'b1;
            end
            PH_DATA:
            begin
                raw       = ent_reg.data_byte;
                stuffed   = 1'b1;
                crc_phase = 1'b1;
            end
            PH_CLO:
            begin
                raw     = crc_reg[7:0];
                stuffed = 1'b1;
            end
            PH_CHI:
            begin
                raw     = crc_reg[15:8];
                stuffed = 1'b1;
            end
            PH_TAIL:
            begin
                raw = BYTE_TAIL;
            end
            default:
            begin
                raw = BYTE_PREAMBLE;
            end
        endcase
    end

    // stuffing: escape lead byte then substitute byte
    assign special = stuffed && (raw inside {BYTE_PREAMBLE, BYTE_ESC_A,
                                             BYTE_TAIL, BYTE_ESC_B});

    always_comb
    begin
        if (esc_reg)
            emit = (raw == BYTE_PREAMBLE || raw == BYTE_TAIL) ? BYTE_SUB_2 : BYTE_SUB_1;
        else if (special)
            emit = (raw == BYTE_PREAMBLE || raw == BYTE_ESC_A) ? BYTE_ESC_A : BYTE_ESC_B;
        else
            emit = raw;
    end

    assign byte_done  = esc_reg || !special;
    assign step       = active_reg && (!ovalid_reg || m_tready);
    assign entry_done = byte_done && (phase_reg == PH_TAIL ||
                        (phase_reg == PH_DATA && !ent_reg.last_byte));
    assign load       = pop_valid && (!active_reg || (step && entry_done));
    assign pop_ready  = load;

    // sequencer
    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        esc_next    = esc_reg;
        crc_next    = crc_reg;
        ent_next    = ent_reg;
        if (step)
        begin
            esc_next = !byte_done;
            if (crc_phase && !esc_reg)
                crc_next = crc_update(crc_reg, raw);
            if (byte_done)
            begin
                case (phase_reg)
                    PH_PRE:
                    begin
                        if (cnt_reg == CNT_W'(PREAMBLE_COUNT - 1))
                        begin
                            phase_next = PH_HDR;
                            cnt_next   = '0;
                        end
                        else
                            cnt_next = cnt_reg + 1'b1;
                    end
                    PH_HDR:
                    begin
                        if (cnt_reg == CNT_W'(HDR_BYTES - 1))
                            phase_next = PH_DATA;
                        else
                            cnt_next = cnt_reg + 1'b1;
                    end
                    PH_DATA:
                    begin
                        if (ent_reg.last_byte)
                            phase_next = PH_CLO;
                        else
                            active_next = 1'b0;
                    end
                    PH_CLO:
                    begin
                        phase_next = PH_CHI;
                    end
                    PH_CHI:
                    begin
                        phase_next = PH_TAIL;
                    end
                    PH_TAIL:
                    begin
                        active_next = 1'b0;
                        crc_next    = '0;
                    end
                    default:
                    begin
                        active_next = 1'b0;
                    end
                endcase
            end
        end
        if (load)
        begin
            active_next = 1'b1;
            phase_next  = pop_entry.first_byte ? PH_PRE : PH_DATA;
            cnt_next    = '0;
            esc_next    = 1'b0;
            ent_next    = pop_entry;
        end
    end

    // output register
    always_comb
    begin
        ovalid_next = ovalid_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        oend_next   = oend_reg;
        if (step)
        begin
            ovalid_next = 1'b1;
            obyte_next  = emit;
            olast_next  = entry_done;
            oend_next   = (phase_reg == PH_TAIL);
        end
        else if (m_tready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= PH_PRE;
            cnt_reg    <= '0;
            esc_reg    <= 1'b0;
            crc_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            esc_reg    <= esc_next;
            crc_reg    <= crc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ent_reg   <= ent_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
        oend_reg  <= oend_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = obyte_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = oend_reg;

endmodule

`default_nettype wire

### sv/escaped_crc16_frame_encoder.sv
// first line byte of a word passes through the queue, the sequencer's word register and the output register
// the line side moves one byte per cycle while m_tready holds and words are queued; a plain data word gives
// one line byte, an escaped one two, a frame's first word adds 8 preamble and 14 to 22 header
// bytes, and the last word adds 3 to 5 bytes of crc and tail
// rate is set by the single byte sequencer in the back part
// reset clears registers to their defaults, empties the queue, zeroes the crc
// ---------------------------------------------------------------------------
// escaped_crc16_frame_encoder
// byte-stuffed frame encoder with crc-16/arc and an apb register file
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module escaped_crc16_frame_encoder (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [ecfe_pkg::ADDR_W-1:0]  paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [23:0]                  s_tdata,   // data_byte[7:0], field_length[23:8]
    input  wire                          s_tlast,   // last_byte
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [7:0]                   m_tdata,   // line_byte
    output logic                         m_tlast,   // run_last
    output logic                         m_tuser    // frame_end
);
    import ecfe_pkg::*;

    logic [15:0]        dest_reg,     dest_next;
    logic [15:0]        source_reg,   source_next;
    logic [15:0]        protocol_reg, protocol_next;
    logic               wr_en;
    logic [1:0]         reg_idx;
    ecfe_hdr_t          hdr;
    logic               push_valid;
    logic               push_ready;
    ecfe_entry_t        push_entry;
    logic               pop_valid;
    logic               pop_ready;
    ecfe_entry_t        pop_entry;
    logic [QCNT_W-1:0]  q_count;

    // register file
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        dest_next     = dest_reg;
        source_next   = source_reg;
        protocol_next = protocol_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_DEST:     dest_next     = pwdata[15:0];
                REG_SOURCE:   source_next   = pwdata[15:0];
                REG_PROTOCOL: protocol_next = pwdata[15:0];
                default:      dest_next     = dest_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_reg     <= DEST_RESET;
            source_reg   <= SOURCE_RESET;
            protocol_reg <= PROTOCOL_RESET;
        end
        else
        begin
            dest_reg     <= dest_next;
            source_reg   <= source_next;
            protocol_reg <= protocol_next;
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_DEST:     prdata = {16'h0000, dest_reg};
            REG_SOURCE:   prdata = {16'h0000, source_reg};
            REG_PROTOCOL: prdata = {16'h0000, protocol_reg};
            default:      prdata = '0;
        endcase
    end

    assign hdr.dest_address   = dest_reg;
    assign hdr.source_address = source_reg;
    assign hdr.protocol_word  = protocol_reg;

    // front part
    ecfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // queue between the parts
    ecfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .count      (q_count)
    );

    // back part
    ecfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr       (hdr),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // checks
    `ASSERT_HOLDS(a_queue_bound, clk, rst_n, q_count <= QCNT_W'(QUEUE_DEPTH))
    `ASSERT_IMPLIES(a_no_push_full, clk, rst_n, s_tvalid && s_tready,
                    q_count != QCNT_W'(QUEUE_DEPTH))
    `ASSERT_IMPLIES(a_tail_ends_word, clk, rst_n, m_tvalid && m_tuser,
                    m_tlast && m_tdata == BYTE_TAIL)
    // a popped word always leaves the sequencer busy in the next cycle
    `ASSERT_NEXT(a_pop_starts_back, clk, rst_n, pop_valid && pop_ready,
                 u_back.active_reg)

endmodule

`default_nettype wire

### tb/sv/escaped_crc16_frame_encoder_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// escaped_crc16_frame_encoder_tb
// self-checking bench: drives data words and apb register writes, predicts
// every line byte of the stuffed, crc-protected frame and checks the output
// stream in order while both stream sides stall at random
// ---------------------------------------------------------------------------

module escaped_crc16_frame_encoder_tb;

    import ecfe_pkg::*;

    localparam int         CLK_PERIOD     = 12;
    localparam int         RESET_CYCLES   = 12;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         TAIL_CYCLES    = 40;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         RANDOM_ITEMS   = 64;
    localparam int         MAX_REPORTS    = 40;
    localparam int         HDR_ZERO_BYTES = 6;
    localparam logic [1:0] REG_UNMAPPED   = 2'd3;

    // one expected line byte
    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_last;
        logic       frame_end;
    } line_beat_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata  = '0;    // data_byte[7:0], field_length[23:8]
    logic                s_tlast  = 1'b0;  // last_byte
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;          // line_byte
    logic                m_tlast;          // run_last
    logic                m_tuser;          // frame_end

    // encoder shadow state
    logic [15:0]         cfg_dest     = DEST_RESET;
    logic [15:0]         cfg_source   = SOURCE_RESET;
    logic [15:0]         cfg_protocol = PROTOCOL_RESET;
    logic                pred_in_frame = 1'b0;
    logic [15:0]         pred_crc      = '0;
    logic [8:0]          step_bytes[$];    // {tail, byte} of the current word
    line_beat_t          expected_beats[$];
    line_beat_t          head_beat;

    // bookkeeping
    int                  error_count   = 0;
    int                  words_sent    = 0;
    int                  frames_closed = 0;
    int                  bytes_checked = 0;
    int                  reg_writes    = 0;
    int                  stall_cycles  = 0;
    bit                  gaps_on       = 1'b1;
    int                  hold_requests = 0;
    int                  hold_taken    = 0;
    int                  hold_left     = 0;

    escaped_crc16_frame_encoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // reflected crc-16/arc, one byte
    function automatic logic [15:0] crc16_arc_next(input logic [15:0] crc,
                                                   input logic [7:0]  b);
        logic [15:0] c;
        int          k;
        c = crc ^ {8'h00, b};
        for (k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // the four bytes that need stuffing
    function automatic logic [7:0] escape_code(input int k);
        case (k)
            0:       return BYTE_PREAMBLE;
            1:       return BYTE_ESC_A;
            2:       return BYTE_TAIL;
            default: return BYTE_ESC_B;
        endcase
    endfunction

    // data byte biased toward the stuffed codes
    function automatic logic [7:0] rand_data_byte();
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(0, 9) < 4)
            return escape_code($urandom_range(0, 3));
        return r[7:0];
    endfunction

    // register value biased toward the extremes
    function automatic logic [15:0] rand_reg_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return r[15:0];
        endcase
    endfunction

    // line byte builders for one accepted word
    task automatic emit_raw(input logic [7:0] b, input logic tail);
        step_bytes.insert(step_bytes.size(), {tail, b});
    endtask

    task automatic emit_stuffed(input logic [7:0] b);
        case (b)
            BYTE_PREAMBLE:
            begin
                emit_raw(BYTE_ESC_A, 1'b0);
                emit_raw(BYTE_SUB_2, 1'b0);
            end
            BYTE_ESC_A:
            begin
                emit_raw(BYTE_ESC_A, 1'b0);
                emit_raw(BYTE_SUB_1, 1'b0);
            end
            BYTE_TAIL:
            begin
                emit_raw(BYTE_ESC_B, 1'b0);
                emit_raw(BYTE_SUB_2, 1'b0);
            end
            BYTE_ESC_B:
            begin
                emit_raw(BYTE_ESC_B, 1'b0);
                emit_raw(BYTE_SUB_1, 1'b0);
            end
            default:
                emit_raw(b, 1'b0);
        endcase
    endtask

    task automatic emit_body(input logic [7:0] b);
        pred_crc = crc16_arc_next(pred_crc, b);
        emit_stuffed(b);
    endtask

    task automatic emit_body_word(input logic [15:0] w);
        emit_body(w[7:0]);
        emit_body(w[15:8]);
    endtask

    // expected line bytes for one accepted data word
    task automatic predict_line_bytes(input logic [7:0]  d,
                                      input logic [15:0] len,
                                      input logic        last);
        line_beat_t beat;
        int         k;
        if (!pred_in_frame)
        begin
            pred_crc = '0;
            repeat (PREAMBLE_COUNT) emit_raw(BYTE_PREAMBLE, 1'b0);
            emit_body_word(cfg_dest);
            emit_body_word(cfg_source);
            repeat (HDR_ZERO_BYTES) emit_body(BYTE_ZERO);
            emit_body_word(cfg_protocol);
            emit_body_word(len);
            pred_in_frame = 1'b1;
        end
        emit_body(d);
        if (last)
        begin
            emit_stuffed(pred_crc[7:0]);
            emit_stuffed(pred_crc[15:8]);
            emit_raw(BYTE_TAIL, 1'b1);
            pred_in_frame = 1'b0;
            pred_crc      = '0;
        end
        for (k = 0; k < step_bytes.size(); k++)
        begin
            beat.line_byte = step_bytes[k][7:0];
            beat.frame_end = step_bytes[k][8];
            beat.run_last  = (k == step_bytes.size() - 1);
            expected_beats.insert(expected_beats.size(), beat);
        end
        step_bytes.delete();
    endtask

    // predict on accepted input words, check accepted output words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_line_bytes(s_tdata[7:0], s_tdata[23:8], s_tlast);
                if (s_tlast)
                    frames_closed++;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t unexpected word: expected none, actual byte %h last %b end %b",
                                 $time, m_tdata, m_tlast, m_tuser);
                end
                else
                begin
                    head_beat = expected_beats.pop_front();
                    bytes_checked++;
                    if (m_tdata !== head_beat.line_byte || m_tlast !== head_beat.run_last ||
                        m_tuser !== head_beat.frame_end)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t mismatch: expected byte %h last %b end %b, actual byte %h last %b end %b",
                                     $time, head_beat.line_byte, head_beat.run_last,
                                     head_beat.frame_end, m_tdata, m_tlast, m_tuser);
                    end
                end
            end
        end
    end

    // output side ready, with random gaps and requested long hold-offs
    always @(posedge clk)
    begin
        if (hold_taken != hold_requests)
        begin
            hold_taken <= hold_requests;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= !(gaps_on && ($urandom_range(0, 99) < 12));
    end

    // watchdog on cycles where nothing moves
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t timeout: nothing moved for %0d cycles, %0d bytes still expected",
                     $time, stall_cycles, expected_beats.size());
            $display("FAIL escaped_crc16_frame_encoder");
            $finish;
        end
    end

    // one apb transfer, setup then access
    task automatic apb_transfer(input  logic        wr,
                                input  logic [1:0]  idx,
                                input  logic [31:0] wdata,
                                output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] value);
        logic [31:0] r;
        logic [31:0] unused_rd;
        r = $urandom;
        apb_transfer(1'b1, idx, {r[31:16], value}, unused_rd);
        case (idx)
            REG_DEST:     cfg_dest     = value;
            REG_SOURCE:   cfg_source   = value;
            REG_PROTOCOL: cfg_protocol = value;
            default:      ;
        endcase
        reg_writes++;
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [15:0] want);
        logic [31:0] got;
        apb_transfer(1'b0, idx, 32'h0, got);
        if (got !== {16'h0000, want})
        begin
            error_count++;
            $display("%0t register %0d read: expected %h, actual %h",
                     $time, idx, {16'h0000, want}, got);
        end
    endtask

    // offer one data word and wait for it to be taken
    task automatic send_word(input logic [7:0] d, input logic [15:0] len,
                             input logic last);
        logic [31:0] r;
        if (gaps_on && ($urandom_range(0, 99) < 12))
        begin
            r = $urandom;
            s_tvalid <= 1'b0;
            s_tdata  <= r[23:0];
            @(posedge clk);
            while ($urandom_range(0, 99) < 40) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, d};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
    endtask

    // stop offering and let every expected byte come out
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // reset values and a single-byte frame with them
    task automatic test_reset_defaults();
        check_reg(REG_DEST, DEST_RESET);
        check_reg(REG_SOURCE, SOURCE_RESET);
        check_reg(REG_PROTOCOL, PROTOCOL_RESET);
        send_word(8'h3C, 16'h0001, 1'b1);
        wait_drain();
    endtask

    // extreme register values, unmapped write ignored, read back
    task automatic test_register_access();
        cfg_write(REG_DEST, 16'hFFFF);
        cfg_write(REG_SOURCE, 16'h0000);
        cfg_write(REG_PROTOCOL, 16'hFFFF);
        cfg_write(REG_UNMAPPED, 16'h1234);
        check_reg(REG_DEST, cfg_dest);
        check_reg(REG_SOURCE, cfg_source);
        check_reg(REG_PROTOCOL, cfg_protocol);
        send_word(8'h00, 16'hFFFF, 1'b0);
        send_word(8'hFF, 16'h0000, 1'b1);
        wait_drain();
    endtask

    // stuffed codes in header and data, length left at zero
    task automatic test_escaped_bytes();
        cfg_write(REG_DEST, {BYTE_ESC_A, BYTE_PREAMBLE});
        cfg_write(REG_SOURCE, {BYTE_ESC_B, BYTE_TAIL});
        cfg_write(REG_PROTOCOL, 16'h0000);
        send_word(BYTE_PREAMBLE, 16'h0000, 1'b0);
        send_word(BYTE_ESC_A, 16'hFFFF, 1'b0);
        send_word(BYTE_TAIL, 16'h0000, 1'b0);
        send_word(BYTE_ESC_B, 16'hFFFF, 1'b0);
        send_word(8'h00, 16'h0000, 1'b0);
        send_word(8'hFF, 16'h0000, 1'b1);
        wait_drain();
    endtask

    // writes inside a frame only reach the next header
    task automatic test_config_mid_frame();
        send_word(8'h11, 16'h0003, 1'b0);
        wait_drain();
        cfg_write(REG_DEST, 16'h0000);
        cfg_write(REG_PROTOCOL, 16'h5AA5);
        send_word(8'h22, 16'h0000, 1'b0);
        send_word(8'h33, 16'h0000, 1'b1);
        send_word(8'h44, 16'h0001, 1'b1);
        wait_drain();
    endtask

    // single-byte frames whose crc low or high byte needs stuffing
    task automatic test_crc_escapes();
        logic [95:0] fixed_hdr;
        logic [15:0] base_crc;
        logic [15:0] len_crc;
        logic [15:0] crc;
        logic [15:0] pick_len;
        logic [7:0]  pick_d;
        int          code;
        int          side;
        int          len;
        int          d;
        int          k;
        bit          found;
        fixed_hdr = {cfg_protocol, 48'h0, cfg_source, cfg_dest};
        base_crc  = '0;
        for (k = 0; k < 12; k++)
            base_crc = crc16_arc_next(base_crc, fixed_hdr[8*k +: 8]);
        for (code = 0; code < 4; code++)
        begin
            for (side = 0; side < 2; side++)
            begin
                found    = 1'b0;
                pick_len = '0;
                pick_d   = '0;
                for (len = 0; len < 65536 && !found; len++)
                begin
                    len_crc = crc16_arc_next(crc16_arc_next(base_crc, len[7:0]), len[15:8]);
                    for (d = 0; d < 256 && !found; d++)
                    begin
                        crc = crc16_arc_next(len_crc, d[7:0]);
                        if (((side == 0) ? crc[7:0] : crc[15:8]) == escape_code(code))
                        begin
                            found    = 1'b1;
                            pick_len = len[15:0];
                            pick_d   = d[7:0];
                        end
                    end
                end
                send_word(pick_d, pick_len, 1'b1);
            end
        end
        wait_drain();
    endtask

    // random frames, mostly short, with register changes while idle
    task automatic test_random_frames();
        logic [31:0] r;
        logic [15:0] len;
        int          sent;
        int          frame_no;
        int          n;
        int          k;
        sent     = 0;
        frame_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // a run of frames with no idling on either side
            gaps_on = !(frame_no >= 8 && frame_no < 14);
            if (frame_no % 5 == 4)
            begin
                wait_drain();
                cfg_write(2'($urandom_range(REG_DEST, REG_PROTOCOL)), rand_reg_value());
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
            for (k = 0; k < n; k++)
            begin
                r = $urandom;
                if (k == 0)
                    len = $urandom_range(0, 1) ? n[15:0] : r[15:0];
                else
                    len = r[15:0];
                if (k == 1 && $urandom_range(0, 7) == 0)
                begin
                    wait_drain();
                    cfg_write(2'($urandom_range(REG_DEST, REG_PROTOCOL)), rand_reg_value());
                end
                send_word(rand_data_byte(), len, k == n - 1);
                sent++;
            end
            frame_no++;
        end
        gaps_on = 1'b1;
        wait_drain();
    endtask

    // output held off for a long stretch while the input keeps offering
    task automatic test_backpressure();
        logic [31:0] r;
        int          k;
        gaps_on = 1'b0;
        hold_requests <= hold_requests + 1;
        for (k = 0; k < 14; k++)
        begin
            r = $urandom;
            send_word(rand_data_byte(), (k == 0) ? 16'd14 : r[15:0], k == 13);
        end
        wait_drain();
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_access();
        test_escaped_bytes();
        test_config_mid_frame();
        test_crc_escapes();
        test_random_frames();
        test_backpressure();

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_beats.size() != 0)
        begin
            error_count++;
            $display("%0t %0d expected bytes never came out", $time, expected_beats.size());
        end

        $display("covered %0d data words in %0d frames, %0d line bytes checked, %0d register writes",
                 words_sent, frames_closed, words_sent == 0 ? 0 : bytes_checked, reg_writes);
        $display("stuffed header, data and crc bytes, mid-frame writes, long output hold-off");
        if (error_count == 0)
            $display("PASS escaped_crc16_frame_encoder");
        else
            $display("FAIL escaped_crc16_frame_encoder");
        $finish;
    end

endmodule
